/* hdl/mf3_pkg.sv */
// Shared types, sizes and compare helpers for the 3x3 median filter.
package mf3_pkg;

  localparam int IMAGE_WIDTH  = 384;
  localparam int IMAGE_HEIGHT = 288;

  localparam int PIX_W  = 8;
  localparam int OUT_W  = 9;
  localparam int COL_W  = $clog2(IMAGE_WIDTH + 1);
  localparam int ROW_W  = $clog2(IMAGE_HEIGHT + 1);
  localparam int ADDR_W = $clog2(IMAGE_WIDTH);

  typedef logic [PIX_W-1:0]  pix_t;
  typedef logic [COL_W-1:0]  col_idx_t;
  typedef logic [ROW_W-1:0]  row_idx_t;
  typedef logic [ADDR_W-1:0] addr_t;

  // one window column, index 0 = oldest image row
  typedef pix_t [2:0] col_t;
  // whole window, index 0 = oldest column
  typedef col_t [2:0] win_t;

  // one line store entry: same column of the two previous rows
  typedef struct packed {
    pix_t older;
    pix_t newer;
  } lpair_t;

  typedef struct packed {
    logic   en;
    addr_t  addr;
    lpair_t data;
  } lbuf_wr_t;

  function automatic pix_t lo8(input pix_t a, input pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pix_t hi8(input pix_t a, input pix_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic pix_t mid3(input pix_t a, input pix_t b, input pix_t c);
    return lo8(hi8(a, b), hi8(lo8(a, b), c));
  endfunction

endpackage

/* hdl/median_filter_3x3.sv */
// Streaming 3x3 median filter, top level.
//
//   channel | handshake           | payload
//   --------+---------------------+-------------------------------------------
//   input   | in_valid / in_stall | pixel_in
//   output  | out_valid/out_stall | pixel_out, out_row, out_col, frame_last
//
// One request per cycle while no result is held under out_stall; an accepted
// request passes the input register + line store read, window, output register.
// All stages move together; in_stall is high only while a result waits
// under out_stall. Reset clears the scan position and the stage valids only;
// the line store and window are not cleared: before they are filled they
// feed border outputs alone, and those are forced to 0.
module median_filter_3x3 (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] pixel_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] pixel_out,
  output logic [8:0] out_row,
  output logic [8:0] out_col,
  output logic       frame_last
);

  localparam mf3_pkg::col_idx_t LAST_COL = mf3_pkg::COL_W'(mf3_pkg::IMAGE_WIDTH);
  localparam mf3_pkg::row_idx_t LAST_ROW = mf3_pkg::ROW_W'(mf3_pkg::IMAGE_HEIGHT);

  // pipeline enable: everything moves unless a result is held
  logic adv;
  logic in_acc;

  // scan position of the next request
  mf3_pkg::col_idx_t scan_col;
  mf3_pkg::row_idx_t scan_row;

  // stage 1: accepted request, line store read data lands alongside
  logic              s1_valid;
  mf3_pkg::pix_t     s1_pix;
  mf3_pkg::col_idx_t s1_col;
  mf3_pkg::row_idx_t s1_row;
  logic              s1_in_img;
  mf3_pkg::lpair_t   rd_data;
  mf3_pkg::lbuf_wr_t wr;
  mf3_pkg::col_t     new_col;

  // stage 2: window holds this step's neighborhood
  logic              s2_valid;
  logic              s2_border;
  logic              s2_last;
  mf3_pkg::row_idx_t s2_orow;
  mf3_pkg::col_idx_t s2_ocol;
  mf3_pkg::win_t     win;
  mf3_pkg::pix_t     med;

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;
  assign in_acc   = in_valid && adv;

  // raster counters over the padded (H+1) x (W+1) scan
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_col <= '0;
      scan_row <= '0;
    end else if (in_acc) begin
      if (scan_col == LAST_COL) begin
        scan_col <= '0;
        scan_row <= (scan_row == LAST_ROW) ? '0 : scan_row + mf3_pkg::ROW_W'(1);
      end else begin
        scan_col <= scan_col + mf3_pkg::COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid;
    end
  end

  // padding steps carry 0 in place of the pixel
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix <= (scan_row != LAST_ROW && scan_col != LAST_COL) ? pixel_in : '0;
      s1_col <= scan_col;
      s1_row <= scan_row;
    end
  end

  assign s1_in_img = (s1_col != LAST_COL);

  // Read at accept, write back when stage 1 advances. The same column is read
  // again only a full scan line later, so read and write never collide.
  assign wr.en         = adv && s1_valid && s1_in_img;
  assign wr.addr       = s1_col[mf3_pkg::ADDR_W-1:0];
  assign wr.data.older = rd_data.newer;
  assign wr.data.newer = s1_pix;

  // padding column has no line store entry, so it skips the read
  mf3_line_store u_lbuf (
    .clk     (clk),
    .rd_en   (in_acc && scan_col != LAST_COL),
    .rd_addr (scan_col[mf3_pkg::ADDR_W-1:0]),
    .rd_data (rd_data),
    .wr      (wr)
  );

  assign new_col[0] = rd_data.older;
  assign new_col[1] = rd_data.newer;
  assign new_col[2] = s1_pix;

  mf3_window u_win (
    .clk     (clk),
    .en      (adv && s1_valid),
    .load    (s1_in_img),
    .new_col (new_col),
    .win     (win)
  );

  // output lags the scan by one row and one column
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid && (s1_row != '0) && (s1_col != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_orow   <= s1_row - mf3_pkg::ROW_W'(1);
      s2_ocol   <= s1_col - mf3_pkg::COL_W'(1);
      s2_border <= (s1_row == mf3_pkg::ROW_W'(1)) || (s1_col == mf3_pkg::COL_W'(1)) ||
                   (s1_row == LAST_ROW) || s1_in_img == 1'b0;
      s2_last   <= (s1_row == LAST_ROW) && !s1_in_img;
    end
  end

  mf3_median u_med (
    .win (win),
    .med (med)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pixel_out  <= s2_border ? '0 : med;
      out_row    <= mf3_pkg::OUT_W'(s2_orow);
      out_col    <= mf3_pkg::OUT_W'(s2_ocol);
      frame_last <= s2_last;
    end
  end

endmodule

/* hdl/mf3_line_store.sv */
// Two-line pixel store: one registered read port, one write port.
module mf3_line_store (
  input  logic              clk,
  input  logic              rd_en,
  input  mf3_pkg::addr_t    rd_addr,
  output mf3_pkg::lpair_t   rd_data,
  input  mf3_pkg::lbuf_wr_t wr
);

  mf3_pkg::lpair_t mem [mf3_pkg::IMAGE_WIDTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hdl/mf3_window.sv */
// 3x3 pixel window: shifts one column left per step, loads a new column when load is set.
module mf3_window (
  input  logic          clk,
  input  logic          en,
  input  logic          load,
  input  mf3_pkg::col_t new_col,
  output mf3_pkg::win_t win
);

  always_ff @(posedge clk) begin
    if (en) begin
      win[0] <= win[1];
      win[1] <= win[2];
      // padding column: newest column keeps its value
      if (load) begin
        win[2] <= new_col;
      end
    end
  end

endmodule

/* hdl/mf3_median.sv */
// Exact 3x3 median: per-column sort, then min-of-max / mid-of-mid / max-of-min.
module mf3_median (
  input  mf3_pkg::win_t win,
  output mf3_pkg::pix_t med
);

  mf3_pkg::pix_t up [3];
  mf3_pkg::pix_t md [3];
  mf3_pkg::pix_t bt [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      up[c] = mf3_pkg::hi8(mf3_pkg::hi8(win[c][0], win[c][1]), win[c][2]);
      bt[c] = mf3_pkg::lo8(mf3_pkg::lo8(win[c][0], win[c][1]), win[c][2]);
      md[c] = mf3_pkg::mid3(win[c][0], win[c][1], win[c][2]);
    end
  end

  assign med = mf3_pkg::mid3(mf3_pkg::lo8(mf3_pkg::lo8(up[0], up[1]), up[2]),
                             mf3_pkg::mid3(md[0], md[1], md[2]),
                             mf3_pkg::hi8(mf3_pkg::hi8(bt[0], bt[1]), bt[2]));

endmodule

/* hdl/mf3_checker.sv */
// Port-level checks for the median filter, bound to the top level.
module mf3_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] pixel_out,
  input logic [8:0] out_row,
  input logic [8:0] out_col,
  input logic       frame_last
);

  localparam logic [8:0] LAST_OROW = mf3_pkg::OUT_W'(mf3_pkg::IMAGE_HEIGHT - 1);
  localparam logic [8:0] LAST_OCOL = mf3_pkg::OUT_W'(mf3_pkg::IMAGE_WIDTH - 1);

  // input is only held back by a held result
  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    !out_stall |-> !in_stall)
    else $error("input stalled while output free");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pixel_out) &&
      $stable(out_row) && $stable(out_col) && $stable(frame_last))
    else $error("held result changed");

  // frame end sits on the bottom-right border pixel
  a_frame_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_last |-> out_row == LAST_OROW && out_col == LAST_OCOL &&
      pixel_out == 8'd0)
    else $error("frame_last at wrong position");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result after reset");

endmodule

bind median_filter_3x3 mf3_checker u_mf3_checker (.*);
